// ===== src/scan_binning_speckle_filter_assert.svh =====
// Assertion macros for the scan binning speckle filter.
// Used by the top level only; no dependencies.
`ifndef SCAN_BINNING_SPECKLE_FILTER_ASSERT_SVH
`define SCAN_BINNING_SPECKLE_FILTER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SBSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("violation");
// Next-cycle implication checked on every clock edge outside reset.
`define SBSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("violation");
`endif

// ===== src/sbsf_pkg.sv =====
// Package for the scan binning speckle filter: payload structs, codes, tables.
// No dependencies.
package sbsf_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_FILT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [2:0] REG_ANGLE_START = 3'd0;
    localparam logic [2:0] REG_BIN_SCALE   = 3'd1;
    localparam logic [2:0] REG_RANGE_LIMIT = 3'd2;
    localparam logic [2:0] REG_MIN_POINTS  = 3'd3;
    localparam logic [2:0] REG_WINDOW      = 3'd4;
    localparam logic [2:0] REG_MIN_NEIGH   = 3'd5;
    localparam logic [2:0] REG_TOLERANCE   = 3'd6;
    localparam logic [2:0] REG_WRAP        = 3'd7;

    localparam int CFG_W = 24;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] x_mm;
        logic signed [15:0] y_mm;
        logic [9:0]         bin_index;
    } in_item_t;

    typedef struct packed {
        logic        landed;
        logic [15:0] range_mm;
        logic [7:0]  hit_count;
        logic [10:0] removed_bins;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GEOM,
        ST_BIN,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_READ_RD,
        ST_CLEAR,
        ST_F_CTR,
        ST_F_CTR_W,
        ST_F_NB,
        ST_F_NB_W,
        ST_F_DEC,
        ST_DONE
    } state_t;

    // Geometry unit status toward the sequencer. The angle can land just past
    // half a turn, so it carries two bits above the 16-bit binary angle.
    typedef struct packed {
        logic        done;
        logic [15:0] range;
        logic signed [17:0] theta;
    } geom_stat_t;

    function automatic logic [23:0] atan_tab(input logic [3:0] i);
        logic [23:0] v;
        begin
            case (i)
                4'd0:  v = 24'd2097152;
                4'd1:  v = 24'd1238021;
                4'd2:  v = 24'd654136;
                4'd3:  v = 24'd332050;
                4'd4:  v = 24'd166669;
                4'd5:  v = 24'd83416;
                4'd6:  v = 24'd41718;
                4'd7:  v = 24'd20860;
                4'd8:  v = 24'd10430;
                4'd9:  v = 24'd5215;
                4'd10: v = 24'd2608;
                4'd11: v = 24'd1304;
                4'd12: v = 24'd652;
                4'd13: v = 24'd326;
                4'd14: v = 24'd163;
                4'd15: v = 24'd81;
                default: v = 24'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== src/sbsf_geom.sv =====
// Iterative range and angle unit: bit-pair square root and 16-step CORDIC.
// Depends on sbsf_pkg.
module sbsf_geom (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic signed [15:0]  x_in,
    input  logic signed [15:0]  y_in,
    output sbsf_pkg::geom_stat_t stat
);
    import sbsf_pkg::*;

    logic               run_reg, run_next;
    logic [4:0]         step_reg, step_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        root_reg, root_next;
    logic [31:0]        bit_reg, bit_next;
    logic signed [26:0] cx_reg, cx_next;
    logic signed [26:0] cy_reg, cy_next;
    logic signed [25:0] acc_reg, acc_next;
    logic               zero_reg, zero_next;
    logic               done_reg, done_next;

    logic signed [31:0] sq_x, sq_y;
    logic [31:0]        sum_sq;
    logic signed [26:0] x0, y0, xs, ys;
    logic [3:0]         idx;
    logic signed [25:0] acc_rnd;

    always_comb
    begin
        sq_x = 32'(x_in) * 32'(x_in);
        sq_y = 32'(y_in) * 32'(y_in);
        sum_sq = 32'(sq_x) + 32'(sq_y);
        x0 = {{3{x_in[15]}}, x_in, 8'd0};
        y0 = {{3{y_in[15]}}, y_in, 8'd0};
        idx = step_reg[3:0];
        xs = cx_reg >>> idx;
        ys = cy_reg >>> idx;
        acc_rnd = acc_reg + 26'sd128;

        run_next = run_reg;
        step_next = step_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        bit_next = bit_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        acc_next = acc_reg;
        zero_next = zero_reg;
        done_next = 1'b0;

        if (go)
        begin
            run_next = 1'b1;
            step_next = 5'd0;
            rem_next = sum_sq;
            root_next = 32'd0;
            bit_next = 32'h4000_0000;
            zero_next = (x_in == 16'sd0) && (y_in == 16'sd0);
            if (x_in < 0)
            begin
                cx_next = -x0;
                cy_next = -y0;
                acc_next = (y_in >= 0) ? 26'sd8388608 : -26'sd8388608;
            end
            else
            begin
                cx_next = x0;
                cy_next = y0;
                acc_next = 26'sd0;
            end
        end
        else if (run_reg)
        begin
            if (rem_reg >= root_reg + bit_reg)
            begin
                rem_next = rem_reg - (root_reg + bit_reg);
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (cy_reg > 0)
            begin
                cx_next = cx_reg + ys;
                cy_next = cy_reg - xs;
                acc_next = acc_reg + 26'(atan_tab(idx));
            end
            else
            begin
                cx_next = cx_reg - ys;
                cy_next = cy_reg + xs;
                acc_next = acc_reg - 26'(atan_tab(idx));
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'd15)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        bit_reg <= bit_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        acc_reg <= acc_next;
        zero_reg <= zero_next;
    end

    assign stat.done = done_reg;
    assign stat.range = root_reg[15:0];
    assign stat.theta = zero_reg ? 18'sd0 : acc_rnd[25:8];
endmodule

// ===== src/scan_binning_speckle_filter.sv =====
// Top level of the scan binning speckle filter: sequencer and bin memory.
// Depends on sbsf_pkg, sbsf_geom and scan_binning_speckle_filter_assert.svh.
//
//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------
//  command   | start / busy        | cmd (in_item_t)
//  result    | done (one cycle)    | result (out_item_t)
//  config    | cfg_we              | cfg_index, cfg_data
//
// Add point runs 16 iterations of the shared root/CORDIC unit, then a
// bin-index multiply, then a read-modify-write of one bin. Clear walks the
// memory at one bin per cycle. A filter pass reads each bin and, for a valid
// bin with fewer hits than min_points, each of its 2*neighbor_window
// neighbors through the single read port.
// After reset the bin contents are undefined until a clear transaction runs.
// The result receiver cannot stall; each result is shown for one cycle.
`include "scan_binning_speckle_filter_assert.svh"
module scan_binning_speckle_filter #(
    parameter int NUM_BINS = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  sbsf_pkg::in_item_t     cmd,
    output logic                   done,
    output sbsf_pkg::out_item_t    result,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [23:0]            cfg_data
);
    import sbsf_pkg::*;

    localparam int AW = $clog2(NUM_BINS);

    // Configuration registers.
    logic signed [15:0] angle_start_reg;
    logic [23:0]        bin_scale_reg;
    logic [15:0]        range_limit_reg;
    logic [7:0]         min_points_reg;
    logic [4:0]         window_reg;
    logic [5:0]         min_neigh_reg;
    logic [15:0]        tolerance_reg;
    logic               wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= -16'sd32768;
            bin_scale_reg <= 24'd262144;
            range_limit_reg <= 16'd12000;
            min_points_reg <= 8'd2;
            window_reg <= 5'd2;
            min_neigh_reg <= 6'd2;
            tolerance_reg <= 16'd50;
            wrap_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE_START: angle_start_reg <= cfg_data[15:0];
                REG_BIN_SCALE:   bin_scale_reg <= cfg_data;
                REG_RANGE_LIMIT: range_limit_reg <= cfg_data[15:0];
                REG_MIN_POINTS:  min_points_reg <= cfg_data[7:0];
                REG_WINDOW:      window_reg <= cfg_data[4:0];
                REG_MIN_NEIGH:   min_neigh_reg <= cfg_data[5:0];
                REG_TOLERANCE:   tolerance_reg <= cfg_data[15:0];
                REG_WRAP:        wrap_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Bin memory: range and hits in one word, one port, registered read.
    logic [23:0] bin_mem [NUM_BINS];
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [23:0]   mem_wdata;
    logic [23:0]   mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= bin_mem[mem_addr];
    end

    // Sequencer registers.
    state_t        state_reg, state_next;
    in_item_t      cmd_reg, cmd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [AW-1:0] bin_reg, bin_next;
    logic          land_reg, land_next;
    logic signed [6:0]  off_reg, off_next;
    logic [15:0]   crange_reg, crange_next;
    logic [5:0]    sim_reg, sim_next;
    logic [10:0]   removed_reg, removed_next;
    logic          nb_ok_reg, nb_ok_next;
    logic [AW-1:0] nb_reg, nb_next;
    logic signed [43:0] prod_reg, prod_next;
    logic          done_reg, done_next;
    out_item_t     res_reg, res_next;

    logic                geom_go;
    geom_stat_t          gstat;

    sbsf_geom u_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (geom_go),
        .x_in  (cmd_reg.x_mm),
        .y_in  (cmd_reg.y_mm),
        .stat  (gstat)
    );

    logic signed [18:0] dtheta;
    logic [43:0]        prod_abs;
    logic [19:0]        idx_mag;
    logic [15:0]        rd_range;
    logic [7:0]         rd_hits;
    logic               rd_valid;
    logic [16:0]        rdiff;
    logic signed [AW+7:0] nb_pos;
    logic signed [AW+7:0] nb_tmp;
    logic signed [AW+7:0] nb_wrap;
    logic               filt_off;

    always_comb
    begin
        dtheta = 19'(gstat.theta) - 19'(angle_start_reg);
        prod_abs = prod_reg[43] ? 44'(-prod_reg) : 44'(prod_reg);
        idx_mag = prod_abs[43:24];
        rd_range = mem_rdata_reg[23:8];
        rd_hits = mem_rdata_reg[7:0];
        rd_valid = (rd_hits != 8'd0) && (rd_range < range_limit_reg);
        rdiff = (rd_range >= crange_reg) ? 17'(rd_range - crange_reg)
                                         : 17'(crange_reg - rd_range);
        nb_pos = $signed({1'b0, {7'd0}, bin_reg}) + (AW+8)'(off_reg);
        // A window wider than a small bin ring can need a second fold.
        if (nb_pos < 0)
            nb_tmp = nb_pos + (AW+8)'(NUM_BINS);
        else if (nb_pos >= (AW+8)'(NUM_BINS))
            nb_tmp = nb_pos - (AW+8)'(NUM_BINS);
        else
            nb_tmp = nb_pos;
        if (nb_tmp < 0)
            nb_wrap = nb_tmp + (AW+8)'(NUM_BINS);
        else if (nb_tmp >= (AW+8)'(NUM_BINS))
            nb_wrap = nb_tmp - (AW+8)'(NUM_BINS);
        else
            nb_wrap = nb_tmp;
        filt_off = (min_points_reg == 8'd0) || (window_reg == 5'd0)
                   || (min_neigh_reg == 6'd0);

        state_next = state_reg;
        cmd_next = cmd_reg;
        cnt_next = cnt_reg;
        bin_next = bin_reg;
        land_next = land_reg;
        off_next = off_reg;
        crange_next = crange_reg;
        sim_next = sim_reg;
        removed_next = removed_reg;
        nb_ok_next = nb_ok_reg;
        nb_next = nb_reg;
        prod_next = prod_reg;
        done_next = 1'b0;
        res_next = res_reg;
        geom_go = 1'b0;
        mem_addr = bin_reg;
        mem_we = 1'b0;
        mem_wdata = {range_limit_reg, 8'd0};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    removed_next = 11'd0;
                    cnt_next = '0;
                    bin_next = '0;
                    case (cmd.operation)
                        OP_ADD:  state_next = ST_GEOM;
                        OP_FILT: state_next = ST_F_CTR;
                        OP_READ:
                        begin
                            bin_next = AW'(cmd.bin_index);
                            mem_addr = AW'(cmd.bin_index);
                            land_next = (13'(cmd.bin_index) < 13'(NUM_BINS));
                            state_next = ST_READ_RD;
                        end
                        default: state_next = ST_CLEAR;
                    endcase
                    geom_go = (cmd.operation == OP_ADD);
                end
            end
            ST_GEOM:
            begin
                // Inputs were latched last cycle; restart geometry on them.
                geom_go = 1'b1;
                state_next = ST_BIN;
            end
            ST_BIN:
            begin
                if (gstat.done)
                begin
                    prod_next = 44'(dtheta) * $signed({20'd0, bin_scale_reg});
                    state_next = ST_ADD_RD;
                    cnt_next = '0;
                end
            end
            ST_ADD_RD:
            begin
                land_next = !prod_reg[43] || (idx_mag == 20'd0);
                land_next = land_next && (idx_mag < 20'(NUM_BINS));
                bin_next = AW'(idx_mag);
                mem_addr = AW'(idx_mag);
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                mem_we = land_reg;
                mem_wdata[23:8] = (gstat.range < rd_range) ? gstat.range : rd_range;
                mem_wdata[7:0] = (rd_hits == 8'd255) ? rd_hits : rd_hits + 8'd1;
                res_next = '0;
                res_next.landed = land_reg;
                done_next = 1'b1;
                state_next = ST_DONE;
            end
            ST_READ_RD:
            begin
                state_next = ST_DONE;
                res_next = '0;
                done_next = 1'b1;
                if (land_reg)
                begin
                    res_next.range_mm = mem_rdata_reg[23:8];
                    res_next.hit_count = mem_rdata_reg[7:0];
                end
                // The read was issued in IDLE's transition cycle; the registered data is
                // valid in the cycle after the address, which is this cycle.
            end
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_addr = cnt_reg[AW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(NUM_BINS - 1))
                begin
                    res_next = '0;
                    done_next = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_F_CTR:
            begin
                if (filt_off || cnt_reg == (AW+1)'(NUM_BINS))
                begin
                    res_next = '0;
                    res_next.removed_bins = removed_reg;
                    done_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    bin_next = cnt_reg[AW-1:0];
                    mem_addr = cnt_reg[AW-1:0];
                    state_next = ST_F_CTR_W;
                end
            end
            ST_F_CTR_W:
            begin
                crange_next = rd_range;
                sim_next = 6'd0;
                off_next = -$signed({2'b00, window_reg});
                cnt_next = cnt_reg + 1'b1;
                if (rd_valid && (rd_hits < min_points_reg))
                    state_next = ST_F_NB;
                else
                    state_next = ST_F_CTR;
            end
            ST_F_NB:
            begin
                if (off_reg > $signed({2'b00, window_reg}))
                begin
                    state_next = ST_F_DEC;
                end
                else if (off_reg == 7'sd0)
                begin
                    off_next = off_reg + 7'sd1;
                end
                else
                begin
                    nb_ok_next = wrap_reg || (nb_pos >= 0
                                 && nb_pos < (AW+8)'(NUM_BINS));
                    nb_next = AW'(nb_wrap);
                    mem_addr = AW'(nb_wrap);
                    state_next = ST_F_NB_W;
                end
            end
            ST_F_NB_W:
            begin
                if (nb_ok_reg && rd_valid && rdiff <= 17'(tolerance_reg))
                    sim_next = sim_reg + 6'd1;
                off_next = off_reg + 7'sd1;
                state_next = ST_F_NB;
            end
            ST_F_DEC:
            begin
                if (sim_reg < min_neigh_reg)
                begin
                    mem_we = 1'b1;
                    removed_next = removed_reg + 11'd1;
                end
                state_next = ST_F_CTR;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        cnt_reg <= cnt_next;
        bin_reg <= bin_next;
        land_reg <= land_next;
        off_reg <= off_next;
        crange_reg <= crange_next;
        sim_reg <= sim_next;
        removed_reg <= removed_next;
        nb_ok_reg <= nb_ok_next;
        nb_reg <= nb_next;
        prod_reg <= prod_next;
        res_reg <= res_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign result = res_reg;

    // Every result strobe is shown while the sequencer sits in its done state.
    `SBSF_ASSERT_NEXT(a_done_after_work, clk, rst_n, done_next, state_reg == ST_DONE)
    // No result strobe while the sequencer is idle.
    `SBSF_ASSERT_IMPL(a_idle_no_result, clk, rst_n, state_reg == ST_IDLE, !done_reg)
    // The filter count never exceeds the bins visited.
    `SBSF_ASSERT_IMPL(a_removed_bound, clk, rst_n, state_reg == ST_F_CTR,
        removed_reg <= 11'(cnt_reg))
endmodule
